// ===== hw/rtl/dfla_pkg.sv =====
// ----------------------------------------------------------------------------
// dfla_pkg
// Shared widths, codes, FSM state type and handshake structs for the
// descriptor free-list allocator.
// ----------------------------------------------------------------------------
package dfla_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int ENTRY_W     = IDX_W + 1;   // {has_next, next_link}
  localparam int STATUS_W    = 2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ZERO_COUNT = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;   // latch request and issue the first table read
    logic step;    // one link of the walk
    logic load;    // move the result into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic reject;  // request fails its checks, no walk needed
    logic last;    // current entry is the chain tail
  } dp_stat_t;

  // Table contents after reset: entry i links to i+1, last entry ends the list
  function automatic logic [IDX_W-1:0] reset_link(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] nxt;
    nxt = (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + 1'b1;
    return nxt;
  endfunction

  function automatic logic reset_has_next(input logic [IDX_W-1:0] idx);
    logic hn;
    hn = (idx != IDX_W'(QUEUE_DEPTH - 1));
    return hn;
  endfunction

endpackage

// ===== hw/rtl/dfla_req_if.sv =====
// ----------------------------------------------------------------------------
// dfla_req_if
// Request channel: command, count and head with valid/ready.
// ----------------------------------------------------------------------------
interface dfla_req_if;
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic [dfla_pkg::CNT_W-1:0]  count;
  logic [dfla_pkg::IDX_W-1:0]  head;

  modport source (output valid, command, count, head, input ready);
  modport sink   (input valid, command, count, head, output ready);
endinterface

// ===== hw/rtl/dfla_rsp_if.sv =====
// ----------------------------------------------------------------------------
// dfla_rsp_if
// Result channel: chain head, status and free count with valid/ready.
// ----------------------------------------------------------------------------
interface dfla_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [dfla_pkg::IDX_W-1:0]     chain_head;
  logic [dfla_pkg::STATUS_W-1:0]  status;
  logic [dfla_pkg::CNT_W-1:0]     free_left;

  modport source (output valid, chain_head, status, free_left, input ready);
  modport sink   (input valid, chain_head, status, free_left, output ready);
endinterface

// ===== hw/rtl/dfla_ram.sv =====
// ----------------------------------------------------------------------------
// dfla_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dfla_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hw/rtl/dfla_ctrl.sv =====
// ----------------------------------------------------------------------------
// dfla_ctrl
// Sequencer: accepts one request, steps the link walk, hands the result to
// the output register.
// ----------------------------------------------------------------------------
module dfla_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  input  dfla_pkg::dp_stat_t   stat,
  output dfla_pkg::ctrl_cmd_t  cmd
);

  dfla_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      dfla_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = stat.reject ? dfla_pkg::S_DONE : dfla_pkg::S_WALK;
        end
      end
      dfla_pkg::S_WALK: begin
        if (stat.last) begin
          state_nxt = dfla_pkg::S_DONE;
        end
      end
      dfla_pkg::S_DONE: begin
        if (out_free) begin
          state_nxt = dfla_pkg::S_IDLE;
        end
      end
      default: state_nxt = dfla_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      dfla_pkg::S_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      dfla_pkg::S_WALK: begin
        cmd.step = 1'b1;
      end
      dfla_pkg::S_DONE: begin
        cmd.load = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dfla_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== hw/rtl/dfla_dp.sv =====
// ----------------------------------------------------------------------------
// dfla_dp
// Datapath: descriptor link table, free head and counter, walk registers
// and result register.
// ----------------------------------------------------------------------------
module dfla_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dfla_pkg::ctrl_cmd_t             cmd,
  output dfla_pkg::dp_stat_t              stat,
  input  logic                            in_command,
  input  logic [dfla_pkg::CNT_W-1:0]      in_count,
  input  logic [dfla_pkg::IDX_W-1:0]      in_head,
  output logic [dfla_pkg::IDX_W-1:0]      out_chain_head,
  output logic [dfla_pkg::STATUS_W-1:0]   out_status,
  output logic [dfla_pkg::CNT_W-1:0]      out_free_left
);

  localparam int IDX_W   = dfla_pkg::IDX_W;
  localparam int CNT_W   = dfla_pkg::CNT_W;
  localparam int ENTRY_W = dfla_pkg::ENTRY_W;

  // architectural state
  logic [IDX_W-1:0]                flist_head_r;
  logic [CNT_W-1:0]                free_total_r;
  logic [dfla_pkg::QUEUE_DEPTH-1:0] valid_r;

  // per-request registers
  logic                            cmd_r;
  logic [CNT_W-1:0]                count_r;
  logic [CNT_W-1:0]                rem_r;
  logic [CNT_W-1:0]                len_r;
  logic [IDX_W-1:0]                cur_r;
  logic [IDX_W-1:0]                head_r;
  logic [IDX_W-1:0]                chain_r;
  logic [dfla_pkg::STATUS_W-1:0]   status_r;
  logic                            rd_valid_r;

  logic [IDX_W-1:0]                chain_head_r;
  logic [dfla_pkg::STATUS_W-1:0]   out_status_r;
  logic [CNT_W-1:0]                free_left_r;

  logic                            ram_re, ram_we;
  logic [IDX_W-1:0]                ram_raddr;
  logic [ENTRY_W-1:0]              ram_wdata, ram_rdata;
  logic [IDX_W-1:0]                ent_link;
  logic                            ent_hn;
  logic                            walk_last;
  logic                            is_alloc;
  logic                            zero_cnt, short_cnt;
  logic [IDX_W-1:0]                start_addr;
  logic [CNT_W:0]                  free_sum;

  dfla_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (dfla_pkg::QUEUE_DEPTH)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (cur_r),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // entries never written read back as their reset pattern
  assign ent_link = rd_valid_r ? ram_rdata[IDX_W-1:0] : dfla_pkg::reset_link(cur_r);
  assign ent_hn   = rd_valid_r ? ram_rdata[IDX_W]     : dfla_pkg::reset_has_next(cur_r);

  assign is_alloc  = (in_command == dfla_pkg::CMD_ALLOC);
  assign zero_cnt  = (in_count == '0);
  assign short_cnt = (in_count > free_total_r);

  always_comb begin
    if (cmd_r == dfla_pkg::CMD_ALLOC) begin
      walk_last = (rem_r == '0);
    end else begin
      // runaway chains stop after QUEUE_DEPTH-1 links
      walk_last = !(ent_hn && (len_r < CNT_W'(dfla_pkg::QUEUE_DEPTH)));
    end
  end

  assign stat.reject = is_alloc && (zero_cnt || short_cnt);
  assign stat.last   = walk_last;

  assign start_addr = is_alloc ? flist_head_r : in_head;
  assign ram_re     = cmd.start || (cmd.step && !walk_last);
  assign ram_raddr  = cmd.start ? start_addr : ent_link;
  assign ram_we     = cmd.step && walk_last;
  assign ram_wdata  = (cmd_r == dfla_pkg::CMD_ALLOC) ? {1'b0, ent_link}
                                                     : {1'b1, flist_head_r};
  assign free_sum   = {1'b0, free_total_r} + {1'b0, len_r};

  // architectural state and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flist_head_r <= '0;
      free_total_r <= CNT_W'(dfla_pkg::QUEUE_DEPTH);
      valid_r      <= '0;
    end else begin
      if (ram_we) begin
        valid_r[cur_r] <= 1'b1;
        if (cmd_r == dfla_pkg::CMD_ALLOC) begin
          flist_head_r <= ent_link;
          free_total_r <= free_total_r - count_r;
        end else begin
          flist_head_r <= head_r;
          free_total_r <= (free_sum > (CNT_W + 1)'(dfla_pkg::QUEUE_DEPTH))
                          ? CNT_W'(dfla_pkg::QUEUE_DEPTH) : free_sum[CNT_W-1:0];
        end
      end
    end
  end

  // walk registers
  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_valid_r <= valid_r[ram_raddr];
    end
    if (cmd.start) begin
      cmd_r   <= in_command;
      count_r <= in_count;
      rem_r   <= in_count - CNT_W'(1);
      len_r   <= CNT_W'(1);
      cur_r   <= start_addr;
      head_r  <= in_head;
      if (!is_alloc) begin
        chain_r  <= '0;
        status_r <= dfla_pkg::ST_OK;
      end else if (zero_cnt) begin
        chain_r  <= '0;
        status_r <= dfla_pkg::ST_ZERO_COUNT;
      end else if (short_cnt) begin
        chain_r  <= '0;
        status_r <= dfla_pkg::ST_NO_SPACE;
      end else begin
        chain_r  <= flist_head_r;
        status_r <= dfla_pkg::ST_OK;
      end
    end else if (cmd.step && !walk_last) begin
      cur_r <= ent_link;
      rem_r <= rem_r - CNT_W'(1);
      len_r <= len_r + CNT_W'(1);
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chain_head_r <= chain_r;
      out_status_r <= status_r;
      free_left_r  <= free_total_r;
    end
  end

  assign out_chain_head = chain_head_r;
  assign out_status     = out_status_r;
  assign out_free_left  = free_left_r;

endmodule

// ===== hw/rtl/descriptor_free_list_allocator_top.sv =====
// ----------------------------------------------------------------------------
// descriptor_free_list_allocator_top
// Linked free-list allocator over a table of queue descriptors.
// ----------------------------------------------------------------------------
// Sequence: an allocate of n descriptors walks n entries of the link table; a free
//   walks its whole chain of L entries; a rejected allocate skips the walk.
// Throughput: one request at a time; one table read per link through the
//   registered read port of the link RAM, so a new request is taken in the
//   cycle after the previous result is loaded into the output register.
// Reset: synchronous; free head 0, free count 256, per-entry valid bits
//   cleared so the table reads as its reset chain at once (no clearing pass).
module descriptor_free_list_allocator_top (
  input  logic        clk,
  input  logic        rst_n,
  dfla_req_if.sink    in_req,
  dfla_rsp_if.source  out_rsp
);

  dfla_pkg::ctrl_cmd_t ctrl_cmd;
  dfla_pkg::dp_stat_t  dp_stat;

  dfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_req.ready),
    .out_valid (out_rsp.valid),
    .out_ready (out_rsp.ready),
    .stat      (dp_stat),
    .cmd       (ctrl_cmd)
  );

  dfla_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (ctrl_cmd),
    .stat           (dp_stat),
    .in_command     (in_req.command),
    .in_count       (in_req.count),
    .in_head        (in_req.head),
    .out_chain_head (out_rsp.chain_head),
    .out_status     (out_rsp.status),
    .out_free_left  (out_rsp.free_left)
  );

endmodule

// ===== hw/rtl/dfla_checker.sv =====
// ----------------------------------------------------------------------------
// dfla_checker
// Port-level checks for the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module dfla_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [dfla_pkg::IDX_W-1:0]     chain_head,
  input logic [dfla_pkg::STATUS_W-1:0]  status,
  input logic [dfla_pkg::CNT_W-1:0]     free_left
);

  // one request in flight: no transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while previous one in flight");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (status == dfla_pkg::ST_OK || status == dfla_pkg::ST_NO_SPACE ||
                   status == dfla_pkg::ST_ZERO_COUNT))
    else $error("undefined status code");

  a_reject_head: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status != dfla_pkg::ST_OK) |-> (chain_head == '0))
    else $error("rejected allocate returned nonzero chain head");

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (free_left <= dfla_pkg::CNT_W'(dfla_pkg::QUEUE_DEPTH)))
    else $error("free count above table size");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(chain_head) &&
                                   $stable(status) && $stable(free_left)))
    else $error("stalled result changed");

endmodule

bind descriptor_free_list_allocator_top dfla_checker u_dfla_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_req.valid),
  .in_ready   (in_req.ready),
  .out_valid  (out_rsp.valid),
  .out_ready  (out_rsp.ready),
  .chain_head (out_rsp.chain_head),
  .status     (out_rsp.status),
  .free_left  (out_rsp.free_left)
);
